>>> hdl/lad_pkg.sv
`timescale 1ns / 1ps

package lad_pkg;

	// Configuration register indexes and port widths.
	localparam int CFG_INDEX_WIDTH = 2;
	localparam int CFG_DATA_WIDTH  = 16;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_STAGE_GAIN    = 2'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_FEEDBACK_GAIN = 2'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_HIGHPASS_MODE = 2'd2;

	// Gain formats: feedback gain is Q3.13, stage gain is Q0.16.
	localparam int FB_SHIFT   = 13;
	localparam int GAIN_WIDTH = 16;
	localparam int GAIN_SHIFT = 16;

	// Soft clip table: tanh(i/4) for i = 0..16, Q0.16.
	localparam int TANH_FRAC = 16;
	localparam int TANH_IDX_WIDTH = 5;
	localparam logic [TANH_FRAC:0] TANH_ONE = 17'h10000;

	typedef logic [TANH_FRAC-1:0] tanh_word_t;

	function automatic tanh_word_t tanh_entry(input logic [TANH_IDX_WIDTH-1:0] idx);
		tanh_word_t val;
		case (idx)
			5'd0:    val = 16'd0;
			5'd1:    val = 16'd16051;
			5'd2:    val = 16'd30285;
			5'd3:    val = 16'd41625;
			5'd4:    val = 16'd49911;
			5'd5:    val = 16'd55593;
			5'd6:    val = 16'd59320;
			5'd7:    val = 16'd61694;
			5'd8:    val = 16'd63179;
			5'd9:    val = 16'd64096;
			5'd10:   val = 16'd64659;
			5'd11:   val = 16'd65003;
			5'd12:   val = 16'd65212;
			5'd13:   val = 16'd65339;
			5'd14:   val = 16'd65417;
			5'd15:   val = 16'd65464;
			default: val = 16'd65492;
		endcase
		return val;
	endfunction

endpackage

>>> hdl/lad_in_if.sv
`timescale 1ns / 1ps

// Input sample channel.
interface lad_in_if #(
	parameter int SAMPLE_WIDTH = 16
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

>>> hdl/lad_out_if.sv
`timescale 1ns / 1ps

// Output sample channel.
interface lad_out_if #(
	parameter int SAMPLE_WIDTH = 16
) ();
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

>>> hdl/lad_front.sv
`timescale 1ns / 1ps

// Input side of the ladder: aligns the sample, subtracts the resonance
// feedback and soft-clips the difference through the interpolated tanh table.
// Four steps from start to u_valid.
module lad_front #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int STATE_WIDTH  = 24
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [SAMPLE_WIDTH-1:0] sample,
	input  logic signed [STATE_WIDTH-1:0]  last_state,
	input  logic [lad_pkg::GAIN_WIDTH-1:0] fb_gain,
	output logic signed [STATE_WIDTH:0]    x,
	output logic                          u_valid,
	output logic signed [STATE_WIDTH-1:0]  u
);

	localparam int W  = STATE_WIDTH;
	localparam int SW = SAMPLE_WIDTH;
	localparam int F  = W - 3;
	localparam int SF = SW - 1;
	localparam int SH = F - 2;
	localparam int XW = W + 1;
	localparam int PW = W + lad_pkg::GAIN_WIDTH + 1;
	localparam int IW = W + lad_pkg::TANH_FRAC - 5;
	localparam int TW = W - 1;

	localparam logic signed [PW-1:0] FB_RND = PW'(1) << (lad_pkg::FB_SHIFT - 1);
	localparam logic [IW-1:0] IP_RND = IW'(1) << (SH - 1);

	logic signed [XW-1:0] x_al;
	logic signed [XW-1:0] x_q;
	logic signed [PW-1:0] fbp_s1;
	logic                 v1_q;
	logic                 v2_q;
	logic                 v3_q;
	logic                 u_valid_q;

	logic signed [PW-1:0]              fbr;
	logic signed [PW-lad_pkg::FB_SHIFT-1:0] fb;
	logic signed [W+4:0]               u_raw;
	logic [W+4:0]                      a;
	logic                              big;
	logic [3:0]                        idx;
	lad_pkg::tanh_word_t               lo;
	lad_pkg::tanh_word_t               hi;

	lad_pkg::tanh_word_t neg_dummy_unused_free;

	logic                neg_s2;
	logic                big_s2;
	lad_pkg::tanh_word_t lo_s2;
	lad_pkg::tanh_word_t d_s2;
	logic [SH-1:0]       frac_s2;

	logic                neg_s3;
	logic                big_s3;
	lad_pkg::tanh_word_t lo_s3;
	logic [IW-1:0]       prod_s3;

	logic [IW-1:0]               ip_rnd;
	logic [lad_pkg::TANH_FRAC:0] t;
	logic [TW-1:0]               ta;
	logic signed [W-1:0]         t_pos;
	logic signed [W-1:0]         u_q;

	// Sample aligned into the state format.
	generate
		if (F >= SF) begin : g_x_up
			assign x_al = XW'(sample) <<< (F - SF);
		end else begin : g_x_dn
			localparam int XSH = SF - F;
			localparam logic signed [SW:0] X_RND = (SW + 1)'(1) << (XSH - 1);
			logic signed [SW:0] x_rnd;
			assign x_rnd = (SW + 1)'(sample) + X_RND;
			assign x_al  = XW'(x_rnd >>> XSH);
		end
	endgenerate

	// Feedback subtraction and table lookup.
	always_comb begin
		fbr   = fbp_s1 + FB_RND;
		fb    = $signed(fbr[PW-1:lad_pkg::FB_SHIFT]);
		u_raw = (W + 5)'(x_q) - (W + 5)'(fb);
		a     = u_raw[W+4] ? (~u_raw + (W + 5)'(1)) : u_raw;
		big   = |a[W+4:W-1];
		idx   = a[W-2:W-5];
		lo    = lad_pkg::tanh_entry({1'b0, idx});
		hi    = lad_pkg::tanh_entry({1'b0, idx} + 5'd1);
	end

	assign neg_dummy_unused_free = hi - lo;

	// Interpolation and alignment of the clipped value.
	always_comb begin
		ip_rnd = prod_s3 + IP_RND;
		if (big_s3) begin
			t = lad_pkg::TANH_ONE;
		end else begin
			t = (lad_pkg::TANH_FRAC + 1)'(lo_s3)
				+ (lad_pkg::TANH_FRAC + 1)'(ip_rnd[IW-1:SH]);
		end
	end

	generate
		if (F >= lad_pkg::TANH_FRAC) begin : g_t_up
			assign ta = TW'(t) << (F - lad_pkg::TANH_FRAC);
		end else begin : g_t_dn
			localparam int TSH = lad_pkg::TANH_FRAC - F;
			localparam logic [lad_pkg::TANH_FRAC+1:0] T_RND =
				(lad_pkg::TANH_FRAC + 2)'(1) << (TSH - 1);
			logic [lad_pkg::TANH_FRAC+1:0] t_rnd;
			assign t_rnd = (lad_pkg::TANH_FRAC + 2)'(t) + T_RND;
			assign ta    = TW'(t_rnd >> TSH);
		end
	endgenerate

	assign t_pos = $signed({1'b0, ta});

	// Step valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_q      <= 1'b0;
			v2_q      <= 1'b0;
			v3_q      <= 1'b0;
			u_valid_q <= 1'b0;
		end else begin
			v1_q      <= start;
			v2_q      <= v1_q;
			v3_q      <= v2_q;
			u_valid_q <= v3_q;
		end
	end

	// Step payload registers.
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x_al;
			fbp_s1 <= last_state * $signed({1'b0, fb_gain});
		end
		if (v1_q) begin
			neg_s2  <= u_raw[W+4];
			big_s2  <= big;
			lo_s2   <= lo;
			d_s2    <= neg_dummy_unused_free;
			frac_s2 <= a[SH-1:0];
		end
		if (v2_q) begin
			neg_s3  <= neg_s2;
			big_s3  <= big_s2;
			lo_s3   <= lo_s2;
			prod_s3 <= IW'(d_s2) * IW'(frac_s2);
		end
		if (v3_q) begin
			u_q <= neg_s3 ? -t_pos : t_pos;
		end
	end

	assign x       = x_q;
	assign u       = u_q;
	assign u_valid = u_valid_q;

endmodule

>>> hdl/lad_pole.sv
`timescale 1ns / 1ps

// One trapezoidal one-pole cell. It holds its own state, takes u from its
// neighbour on the left, registers the gain product and then hands y to the right.
module lad_pole #(
	parameter int STATE_WIDTH = 24
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic signed [STATE_WIDTH-1:0]  u,
	input  logic [lad_pkg::GAIN_WIDTH-1:0] gain,
	output logic                           out_valid,
	output logic signed [STATE_WIDTH-1:0]  y,
	output logic signed [STATE_WIDTH-1:0]  state
);

	localparam int W  = STATE_WIDTH;
	localparam int PW = W + lad_pkg::GAIN_WIDTH + 2;
	localparam int VW = PW - lad_pkg::GAIN_SHIFT;
	localparam logic signed [PW-1:0] V_RND = PW'(1) << (lad_pkg::GAIN_SHIFT - 1);

	logic signed [PW-1:0] p_s1;
	logic                 ph_q;
	logic                 out_valid_q;
	logic signed [W-1:0]  s_q;
	logic signed [W-1:0]  y_q;

	logic signed [PW-1:0] pr;
	logic signed [VW-1:0] v;
	logic signed [W+2:0]  y_w;
	logic signed [W+2:0]  yv;
	logic                 in_range;
	logic signed [W-1:0]  s_next;

	// Rounded gain product, trapezoidal update and state saturation.
	always_comb begin
		pr       = p_s1 + V_RND;
		v        = $signed(pr[PW-1:lad_pkg::GAIN_SHIFT]);
		y_w      = (W + 3)'(s_q) + (W + 3)'(v);
		yv       = y_w + (W + 3)'(v);
		in_range = (&yv[W+2:W-1]) | ~(|yv[W+2:W-1]);
		s_next   = in_range ? yv[W-1:0] : {yv[W+2], {(W - 1){~yv[W+2]}}};
	end

	// Phase flags and the stored state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q        <= 1'b0;
			out_valid_q <= 1'b0;
			s_q         <= '0;
		end else begin
			ph_q        <= in_valid;
			out_valid_q <= ph_q;
			if (ph_q) begin
				s_q <= s_next;
			end
		end
	end

	// Difference times gain, then the output handed on.
	always_ff @(posedge clk) begin
		if (in_valid) begin
			p_s1 <= (u - s_q) * $signed({1'b0, gain});
		end
		if (ph_q) begin
			y_q <= y_w[W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign y         = y_q;
	assign state     = s_q;

endmodule

>>> hdl/four_pole_ladder_filter.sv
`timescale 1ns / 1ps

// Four-pole resonant ladder filter with tanh soft clipping.
// Samples arrive on the dry channel and leave on the wet channel; both use a
// valid/ready handshake and one transfer carries one signed sample.
// Software sets stage_gain (index 0, Q0.16), feedback_gain (index 1, Q3.13)
// and highpass_mode (index 2) through cfg_we/cfg_index/cfg_data while the
// filter is idle; writes to other indexes are dropped.
// The result passes through four front-end steps (feedback multiply, table
// lookup, interpolation multiply, alignment), then two steps in each of the
// four pole cells (gain multiply, update), and then the output register.
// A new sample is taken only after the previous one has reached the output
// register, since each sample needs the last pole state the previous one
// left behind.
// dry.ready is high whenever no sample is in flight; a finished sample may
// wait in the output register while the next one is taken.
// If the receiver stalls, a finished result waits inside until the output
// register frees, and no new sample is taken meanwhile.
// Reset clears all pole states, the configuration registers and the valid flags.
module four_pole_ladder_filter #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int STATE_WIDTH  = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	lad_in_if.sink                              dry,
	lad_out_if.source                           wet,
	input  logic                                cfg_we,
	input  logic [lad_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [lad_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

	localparam int W  = STATE_WIDTH;
	localparam int SW = SAMPLE_WIDTH;
	localparam int F  = W - 3;
	localparam int SF = SW - 1;
	localparam int RW = W + SW + 4;
	localparam int POLES = 4;

	logic [lad_pkg::GAIN_WIDTH-1:0] stage_gain_q;
	logic [lad_pkg::GAIN_WIDTH-1:0] feedback_gain_q;
	logic                           highpass_q;

	logic                  busy_q;
	logic                  pend_q;
	logic                  wet_valid_q;
	logic signed [SW-1:0]  out_q;

	logic                  accept;
	logic                  out_free;
	logic                  load;
	logic signed [W:0]     x;
	logic                  u_valid;
	logic signed [W-1:0]   u;
	logic [POLES-1:0]      pole_valid;
	logic signed [W-1:0]   pole_y [POLES];
	logic signed [W-1:0]   pole_s [POLES];
	logic signed [W-1:0]   last_state;

	logic signed [W+1:0]   res;
	logic signed [RW-1:0]  r;
	logic                  r_in_range;
	logic signed [SW-1:0]  r_sat;

	assign accept     = dry.valid & dry.ready;
	assign last_state = pole_s[POLES-1];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_gain_q    <= '0;
			feedback_gain_q <= '0;
			highpass_q      <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				lad_pkg::REG_STAGE_GAIN:    stage_gain_q    <= cfg_data;
				lad_pkg::REG_FEEDBACK_GAIN: feedback_gain_q <= cfg_data;
				lad_pkg::REG_HIGHPASS_MODE: highpass_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	lad_front #(
		.SAMPLE_WIDTH(SW),
		.STATE_WIDTH (W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept),
		.sample    (dry.sample_in),
		.last_state(last_state),
		.fb_gain   (feedback_gain_q),
		.x         (x),
		.u_valid   (u_valid),
		.u         (u)
	);

	// Chain of pole cells, each fed by its left neighbour.
	generate
		for (genvar i = 0; i < POLES; i++) begin : g_pole
			logic                in_v;
			logic signed [W-1:0] in_u;
			if (i == 0) begin : g_head
				assign in_v = u_valid;
				assign in_u = u;
			end else begin : g_link
				assign in_v = pole_valid[i-1];
				assign in_u = pole_y[i-1];
			end
			lad_pole #(
				.STATE_WIDTH(W)
			) u_pole (
				.clk      (clk),
				.arst_n   (arst_n),
				.in_valid (in_v),
				.u        (in_u),
				.gain     (stage_gain_q),
				.out_valid(pole_valid[i]),
				.y        (pole_y[i]),
				.state    (pole_s[i])
			);
		end
	endgenerate

	// Output mode selection and alignment to the sample format.
	assign res = highpass_q ? ((W + 2)'(x) - (W + 2)'(last_state)) : (W + 2)'(last_state);

	generate
		if (SF >= F) begin : g_r_up
			assign r = RW'(res) <<< (SF - F);
		end else begin : g_r_dn
			localparam logic signed [RW-1:0] R_RND = RW'(1) << (F - SF - 1);
			logic signed [RW-1:0] r_rnd;
			assign r_rnd = RW'(res) + R_RND;
			assign r     = r_rnd >>> (F - SF);
		end
	endgenerate

	assign r_in_range = (&r[RW-1:SW-1]) | ~(|r[RW-1:SW-1]);
	assign r_sat      = r_in_range ? r[SW-1:0] : {r[RW-1], {(SW - 1){~r[RW-1]}}};

	assign out_free = ~wet_valid_q | wet.ready;
	assign load     = (pole_valid[POLES-1] | pend_q) & out_free;

	// Item control and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			pend_q      <= 1'b0;
			wet_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				pend_q <= 1'b0;
			end else if (pole_valid[POLES-1]) begin
				pend_q <= 1'b1;
			end
			if (load) begin
				wet_valid_q <= 1'b1;
			end else if (wet.ready) begin
				wet_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= r_sat;
		end
	end

	assign dry.ready      = ~busy_q;
	assign wet.valid      = wet_valid_q;
	assign wet.sample_out = out_q;

	// A transfer on the dry side starts an item.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("item not marked busy after input transfer");

	// The last cell finishes only inside an item.
	a_done_in_item: assert property (@(posedge clk) disable iff (!arst_n)
		pole_valid[POLES-1] |-> busy_q)
		else $error("last pole finished outside an item");

	// Filter state moves only while an item is at work.
	a_state_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |=> $stable(last_state))
		else $error("pole state changed while idle");

	// A waiting result is kept while the output register stays full.
	a_pend_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q && wet_valid_q && !wet.ready) |=> pend_q)
		else $error("waiting result lost during stall");

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int SAMPLE_WIDTH = 16;
	localparam int STATE_WIDTH  = 24;
	localparam int POLES        = 4;
	localparam int STATE_FRAC   = STATE_WIDTH - 3;
	localparam int SAMPLE_FRAC  = SAMPLE_WIDTH - 1;
	localparam int CLIP_SHIFT   = STATE_FRAC - 2;
	localparam longint UNITY_TANH = 65536;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 5;
	localparam int SETTLE_CYCLES  = 16;
	localparam int TAIL_CYCLES    = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int IDLE_PERCENT   = 8;
	localparam int HOLD_AT        = 520;
	localparam int HOLD_CYCLES    = 300;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 160;

	// Index with no register behind it; writes there must have no effect.
	localparam logic [lad_pkg::CFG_INDEX_WIDTH-1:0] REG_SPARE = 2'd3;

	// tanh(i/4) for i = 0..16 in Q0.16.
	localparam longint TANH_POINTS [17] = '{
		0, 16051, 30285, 41625, 49911, 55593, 59320, 61694, 63179,
		64096, 64659, 65003, 65212, 65339, 65417, 65464, 65492
	};

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] sample_out;
	} filtered_t;

	logic                                clk = 1'b0;
	logic                                arst_n;
	logic                                cfg_we;
	logic [lad_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
	logic [lad_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

	lad_in_if  #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) dry_ch ();
	lad_out_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) wet_ch ();

	four_pole_ladder_filter #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH),
		.STATE_WIDTH (STATE_WIDTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.dry      (dry_ch),
		.wet      (wet_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Filter state and settings as the predictor sees them.
	logic signed [STATE_WIDTH-1:0]      pole_state [POLES];
	logic [lad_pkg::GAIN_WIDTH-1:0]     stage_gain_q;
	logic [lad_pkg::GAIN_WIDTH-1:0]     feedback_gain_q;
	logic                               highpass_q;

	logic signed [SAMPLE_WIDTH-1:0] dry_samples [$];
	filtered_t                      predicted_samples [$];

	int idle_pct;
	int mismatches      = 0;
	int samples_taken   = 0;
	int results_checked = 0;
	int register_writes = 0;
	int settings_used   = 0;
	int quiet_cycles    = 0;
	int hold_left;
	logic hold_done;

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Shift right with rounding to nearest, ties towards plus infinity.
	function automatic longint round_shift(input longint v, input int sh);
		if (sh == 0)
			return v;
		return (v + (longint'(1) <<< (sh - 1))) >>> sh;
	endfunction

	function automatic longint clamp(input longint v, input int w);
		longint hi;
		longint lo;
		hi = (longint'(1) <<< (w - 1)) - 1;
		lo = -hi - 1;
		if (v > hi)
			return hi;
		if (v < lo)
			return lo;
		return v;
	endfunction

	function automatic longint realign(input longint v, input int from_frac, input int to_frac);
		if (to_frac >= from_frac)
			return v <<< (to_frac - from_frac);
		return round_shift(v, from_frac - to_frac);
	endfunction

	// Odd tanh from the table with linear interpolation, exactly one at four and beyond.
	function automatic longint tanh_clip(input longint u);
		logic   neg;
		longint mag;
		longint idx;
		longint frac;
		longint t;
		neg = u < 0;
		mag = neg ? -u : u;
		idx = mag >>> CLIP_SHIFT;
		if (idx >= 16) begin
			t = UNITY_TANH;
		end else begin
			frac = mag & ((longint'(1) <<< CLIP_SHIFT) - 1);
			t = TANH_POINTS[idx] +
				round_shift((TANH_POINTS[idx + 1] - TANH_POINTS[idx]) * frac, CLIP_SHIFT);
		end
		t = realign(t, lad_pkg::TANH_FRAC, STATE_FRAC);
		return neg ? -t : t;
	endfunction

	// One sample through feedback, soft clip and the four poles; updates pole_state.
	function automatic filtered_t ladder_filter_step(input logic signed [SAMPLE_WIDTH-1:0] smp);
		filtered_t res;
		longint x;
		longint u;
		longint s;
		longint v;
		longint y;
		longint out_val;
		x = realign(longint'(smp), SAMPLE_FRAC, STATE_FRAC);
		u = x - round_shift(longint'(pole_state[POLES - 1]) * longint'(feedback_gain_q),
			lad_pkg::FB_SHIFT);
		u = tanh_clip(u);
		for (int i = 0; i < POLES; i++) begin
			s = longint'(pole_state[i]);
			v = round_shift((u - s) * longint'(stage_gain_q), lad_pkg::GAIN_SHIFT);
			y = s + v;
			pole_state[i] = STATE_WIDTH'(clamp(y + v, STATE_WIDTH));
			u = y;
		end
		out_val = longint'(pole_state[POLES - 1]);
		if (highpass_q)
			out_val = x - out_val;
		res.sample_out = SAMPLE_WIDTH'(clamp(realign(out_val, STATE_FRAC, SAMPLE_FRAC),
			SAMPLE_WIDTH));
		return res;
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Drives one register write; the predictor follows it.
	task automatic write_register(input logic [lad_pkg::CFG_INDEX_WIDTH-1:0] idx,
			input logic [lad_pkg::CFG_DATA_WIDTH-1:0] value);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		case (idx)
			lad_pkg::REG_STAGE_GAIN: begin
				stage_gain_q <= value;
			end
			lad_pkg::REG_FEEDBACK_GAIN: begin
				feedback_gain_q <= value;
			end
			lad_pkg::REG_HIGHPASS_MODE: begin
				highpass_q <= value[0];
			end
			default: begin
			end
		endcase
		register_writes++;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_setting(input logic [lad_pkg::GAIN_WIDTH-1:0] gain,
			input logic [lad_pkg::GAIN_WIDTH-1:0] feedback, input logic highpass);
		write_register(lad_pkg::REG_STAGE_GAIN, gain);
		write_register(lad_pkg::REG_FEEDBACK_GAIN, feedback);
		write_register(lad_pkg::REG_HIGHPASS_MODE, {15'($urandom), highpass});
		write_register(REG_SPARE, 16'($urandom));
		settings_used++;
	endtask

	// Wait until every queued sample has been taken and every result has arrived.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (dry_samples.size() != 0 || dry_ch.valid || predicted_samples.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Mostly full-scale noise, with extremes, quiet signal and held levels.
	function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample(
			input logic signed [SAMPLE_WIDTH-1:0] prev);
		int pick;
		pick = $urandom_range(99);
		if (pick < 55)
			return SAMPLE_WIDTH'($urandom);
		if (pick < 70)
			return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
		if (pick < 85)
			return SAMPLE_WIDTH'(int'($urandom_range(64)) - 32);
		return prev;
	endfunction

	// Sender: offers queued samples, idling now and then.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_ch.valid <= 1'b0;
		end else if (!dry_ch.valid || dry_ch.ready) begin
			if (dry_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
				dry_ch.valid     <= 1'b1;
				dry_ch.sample_in <= dry_samples.pop_front();
			end else begin
				dry_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver and checker: compares each output transfer with the oldest prediction,
	// then predicts for any input transfer at the same edge.
	always @(posedge clk or negedge arst_n) begin : receiver
		filtered_t want;
		if (!arst_n) begin
			wet_ch.ready <= 1'b0;
			hold_left    <= 0;
			hold_done    <= 1'b0;
			for (int i = 0; i < POLES; i++)
				pole_state[i] = '0;
		end else begin
			if (wet_ch.valid && wet_ch.ready) begin
				if (predicted_samples.size() == 0) begin
					report_mismatch($sformatf("unexpected output sample %0d",
						wet_ch.sample_out));
				end else begin
					want = predicted_samples.pop_front();
					if (wet_ch.sample_out !== want.sample_out)
						report_mismatch($sformatf("result %0d: sample_out %0d, predicted %0d",
							results_checked, wet_ch.sample_out, want.sample_out));
				end
				results_checked++;
			end
			if (dry_ch.valid && dry_ch.ready) begin
				predicted_samples.push_back(ladder_filter_step(dry_ch.sample_in));
				samples_taken++;
			end

			// One long hold-off so the filter backs up and stalls its input.
			if (!hold_done && results_checked >= HOLD_AT) begin
				hold_left    <= HOLD_CYCLES;
				hold_done    <= 1'b1;
				wet_ch.ready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left    <= hold_left - 1;
				wet_ch.ready <= 1'b0;
			end else begin
				wet_ch.ready <= $urandom_range(99) >= idle_pct;
			end
		end
	end

	// Watchdog: ends the run after too long without any transfer or write.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((dry_ch.valid && dry_ch.ready) || (wet_ch.valid && wet_ch.ready) || cfg_we) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("FAILURE");
					$finish;
				end
			end
		end
	end

	// Stimulus sequence: directed checks, then random phases over several settings.
	initial begin
		logic [lad_pkg::GAIN_WIDTH-1:0] gain;
		logic [lad_pkg::GAIN_WIDTH-1:0] feedback;
		logic                           highpass;
		logic signed [SAMPLE_WIDTH-1:0] prev;

		arst_n           = 1'b0;
		cfg_we           = 1'b0;
		cfg_index        = '0;
		cfg_data         = '0;
		dry_ch.valid     = 1'b0;
		dry_ch.sample_in = '0;
		wet_ch.ready     = 1'b0;
		stage_gain_q     = '0;
		feedback_gain_q  = '0;
		highpass_q       = 1'b0;
		idle_pct         = IDLE_PERCENT;
		prev             = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Registers still at their reset values: the output must stay silent.
		dry_samples.push_back(16'sh0000);
		dry_samples.push_back(16'sh7FFF);
		dry_samples.push_back(16'sh8000);

		// Full stage gain in high-pass mode: full-scale steps drive the output
		// into saturation at both ends.
		wait_drained();
		apply_setting(16'hFFFF, 16'h0000, 1'b1);
		@(negedge clk);
		repeat (4) dry_samples.push_back(16'sh7FFF);
		repeat (4) dry_samples.push_back(16'sh8000);
		dry_samples.push_back(16'sh0001);
		dry_samples.push_back(16'shFFFF);

		// Feedback gain at the top code: the soft clip sees arguments beyond four.
		wait_drained();
		apply_setting(16'hFFFF, 16'hFFFF, 1'b0);
		@(negedge clk);
		repeat (3) begin
			dry_samples.push_back(16'sh7FFF);
			dry_samples.push_back(16'sh8000);
		end
		dry_samples.push_back(16'sh0000);
		dry_samples.push_back(16'sh0000);

		for (int k = 0; k < RANDOM_PHASES; k++) begin
			case (k)
				0: begin
					gain = '0; feedback = '0; highpass = 1'b0;
				end
				1: begin
					gain = 16'hFFFF; feedback = 16'h8000; highpass = 1'b0;
				end
				2: begin
					gain = 16'hFFFF; feedback = 16'hFFFF; highpass = 1'b1;
				end
				3: begin
					// Low cutoff with strong resonance, as in normal use.
					gain = 16'($urandom_range(2000));
					feedback = 16'($urandom_range(32768, 26000));
					highpass = 1'b0;
				end
				default: begin
					gain = 16'($urandom);
					feedback = ($urandom_range(3) == 0) ? 16'($urandom)
						: 16'($urandom_range(32768));
					highpass = 1'($urandom_range(1));
				end
			endcase
			wait_drained();
			apply_setting(gain, feedback, highpass);
			@(negedge clk);
			idle_pct <= (k == 4) ? 0 : IDLE_PERCENT;
			repeat (PHASE_ITEMS) begin
				prev = random_sample(prev);
				dry_samples.push_back(prev);
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (predicted_samples.size() != 0)
			report_mismatch($sformatf("%0d predicted samples never arrived",
				predicted_samples.size()));

		$display("Run covered %0d samples filtered under %0d gain settings with %0d writes.",
			samples_taken, settings_used, register_writes);
		$display("%0d results compared, one %0d-cycle output hold-off, %0d mismatches.",
			results_checked, HOLD_CYCLES, mismatches);
		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

>>> four_pole_ladder_filter.f
hdl/lad_pkg.sv
hdl/lad_in_if.sv
hdl/lad_out_if.sv
hdl/lad_front.sv
hdl/lad_pole.sv
hdl/four_pole_ladder_filter.sv
tb/sv/testbench.sv
